// ----- hw/rtl/pldm_pkg.sv -----
// shared types, constants and arithmetic helpers for the lens distortion mapper
package pldm_pkg;

  typedef logic signed [63:0] val_t;

  // pipeline geometry
  localparam int unsigned NUM_W       = 36;
  localparam int unsigned DIV_STAGES  = NUM_W;
  localparam int unsigned ITERS       = 8;

  // arithmetic constants
  localparam val_t RADIAL_K3  = 64'sd0;
  localparam val_t OP_LIM     = 64'sd2147483647;
  localparam val_t ONE_Q20    = 64'sd1048576;
  localparam val_t OUT_MAX    = 64'sd524287;
  localparam val_t OUT_MIN    = -64'sd524288;
  localparam logic signed [23:0] K1_MIN = 24'sd11;

  // reset values of the registers
  localparam logic [15:0] FOCAL_RST    = 16'd8000;
  localparam logic [15:0] CENTER_X_RST = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST = 16'd3840;

  typedef enum logic [3:0] {
    CFG_FOCAL_X  = 4'd0,
    CFG_FOCAL_Y  = 4'd1,
    CFG_CENTER_X = 4'd2,
    CFG_CENTER_Y = 4'd3,
    CFG_K1       = 4'd4,
    CFG_K2       = 4'd5,
    CFG_P1       = 4'd6,
    CFG_P2       = 4'd7
  } cfg_idx_e;

  // coefficients shared by the divider, iteration and projection stages
  typedef struct packed {
    logic        dist_on;
    val_t        k1;
    val_t        k2;
    val_t        p1;
    val_t        p2;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] cx;
    logic [15:0] cy;
  } coef_t;

  // word travelling through the undistortion iterations
  typedef struct packed {
    logic act;
    val_t ex;
    val_t ey;
    val_t ux;
    val_t uy;
    val_t mx2;
    val_t my2;
    val_t mxy;
    val_t rho2;
    val_t r4;
    val_t rad;
  } it_t;

  // operands clipped to 31 bits magnitude, 32x32 product, floor shift
  function automatic val_t smul(input val_t a, input val_t b, input int unsigned sh);
    logic signed [31:0] a32;
    logic signed [31:0] b32;
    logic signed [63:0] p;
    if (a > OP_LIM) a32 = 32'sh7fffffff;
    else if (a < -OP_LIM) a32 = -32'sh7fffffff;
    else a32 = a[31:0];
    if (b > OP_LIM) b32 = 32'sh7fffffff;
    else if (b < -OP_LIM) b32 = -32'sh7fffffff;
    else b32 = b[31:0];
    p = a32 * b32;
    return p >>> sh;
  endfunction

endpackage

// ----- hw/rtl/pldm_div.sv -----
// pipelined restoring divider: (pixel - centre) * 65536 / focal, one quotient bit a stage
module pldm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                act_i,
  input  logic signed [19:0]  x_i,
  input  logic signed [19:0]  y_i,
  input  pldm_pkg::coef_t     coef_i,
  output logic                valid_o,
  output pldm_pkg::it_t       pt_o
);

  typedef struct packed {
    logic                              act;
    logic signed [19:0]                x;
    logic signed [19:0]                y;
    logic                              neg_x;
    logic                              neg_y;
    logic [pldm_pkg::NUM_W-1:0]        mag_x;
    logic [pldm_pkg::NUM_W-1:0]        mag_y;
    logic [15:0]                       rem_x;
    logic [15:0]                       rem_y;
  } dv_t;

  dv_t  st_q [pldm_pkg::DIV_STAGES+1];
  logic vld_q [pldm_pkg::DIV_STAGES+1];
  dv_t  ld_d;

  logic signed [20:0] diff_x, diff_y;
  logic [20:0]        abs_x, abs_y;

  // one restoring step on a magnitude, quotient bit shifted into the bottom
  function automatic logic [pldm_pkg::NUM_W+15:0] div_step(
    input logic [pldm_pkg::NUM_W-1:0] mag,
    input logic [15:0]                rem,
    input logic [15:0]                d
  );
    logic [16:0] r17;
    logic        ge;
    logic [16:0] rn;
    r17 = {rem, mag[pldm_pkg::NUM_W-1]};
    ge  = (r17 >= {1'b0, d});
    rn  = ge ? (r17 - {1'b0, d}) : r17;
    return {mag[pldm_pkg::NUM_W-2:0], ge, rn[15:0]};
  endfunction

  // numerator magnitude and sign
  always_comb begin
    diff_x = $signed({x_i[19], x_i}) - $signed({5'b0, coef_i.cx});
    diff_y = $signed({y_i[19], y_i}) - $signed({5'b0, coef_i.cy});
    abs_x  = diff_x[20] ? 21'(-diff_x) : 21'(diff_x);
    abs_y  = diff_y[20] ? 21'(-diff_y) : 21'(diff_y);
    ld_d.act   = act_i;
    ld_d.x     = x_i;
    ld_d.y     = y_i;
    ld_d.neg_x = diff_x[20];
    ld_d.neg_y = diff_y[20];
    ld_d.mag_x = {abs_x[19:0], 16'b0};
    ld_d.mag_y = {abs_y[19:0], 16'b0};
    ld_d.rem_x = '0;
    ld_d.rem_y = '0;
  end

  // load stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= ld_d;
    end
  end

  // quotient bit stages
  for (genvar g = 0; g < pldm_pkg::DIV_STAGES; g++) begin : g_stage
    dv_t st_d;

    always_comb begin
      st_d = st_q[g];
      {st_d.mag_x, st_d.rem_x} = div_step(st_q[g].mag_x, st_q[g].rem_x, coef_i.fx);
      {st_d.mag_y, st_d.rem_y} = div_step(st_q[g].mag_y, st_q[g].rem_y, coef_i.fy);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g+1] <= st_d;
      end
    end
  end

  // signed quotient, or the raw point for projection
  always_comb begin
    logic signed [63:0] qx;
    logic signed [63:0] qy;
    qx = $signed({28'b0, st_q[pldm_pkg::DIV_STAGES].mag_x});
    qy = $signed({28'b0, st_q[pldm_pkg::DIV_STAGES].mag_y});
    if (st_q[pldm_pkg::DIV_STAGES].neg_x) qx = -qx;
    if (st_q[pldm_pkg::DIV_STAGES].neg_y) qy = -qy;
    pt_o     = '0;
    pt_o.act = st_q[pldm_pkg::DIV_STAGES].act;
    pt_o.ux  = qx;
    pt_o.uy  = qy;
    if (st_q[pldm_pkg::DIV_STAGES].act) begin
      pt_o.ex = qx;
      pt_o.ey = qy;
    end else begin
      pt_o.ex = 64'(st_q[pldm_pkg::DIV_STAGES].x);
      pt_o.ey = 64'(st_q[pldm_pkg::DIV_STAGES].y);
    end
  end

  assign valid_o = vld_q[pldm_pkg::DIV_STAGES];

endmodule

// ----- hw/rtl/pldm_iter.sv -----
// one undistortion step in four stages: estimate = distorted - delta(estimate)
module pldm_iter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pldm_pkg::it_t   pt_i,
  input  pldm_pkg::coef_t coef_i,
  output logic            valid_o,
  output pldm_pkg::it_t   pt_o
);

  pldm_pkg::it_t a_q, b_q, c_q, d_q;
  pldm_pkg::it_t a_d, b_d, c_d, d_d;
  logic [3:0]    vld_q;

  // squares and cross product
  always_comb begin
    a_d     = pt_i;
    a_d.mx2 = pldm_pkg::smul(pt_i.ex, pt_i.ex, 16);
    a_d.my2 = pldm_pkg::smul(pt_i.ey, pt_i.ey, 16);
    a_d.mxy = pldm_pkg::smul(pt_i.ex, pt_i.ey, 16);
  end

  // radius squared and its square
  always_comb begin
    b_d      = a_q;
    b_d.rho2 = a_q.mx2 + a_q.my2;
    b_d.r4   = pldm_pkg::smul(b_d.rho2, b_d.rho2, 16);
  end

  // radial term
  always_comb begin
    c_d     = b_q;
    c_d.rad = pldm_pkg::smul(coef_i.k1, b_q.rho2, 16) + pldm_pkg::smul(coef_i.k2, b_q.r4, 16);
  end

  // delta and new estimate
  always_comb begin
    pldm_pkg::val_t dx;
    pldm_pkg::val_t dy;
    dx = pldm_pkg::smul(c_q.ex, c_q.rad, 20)
       + pldm_pkg::smul(coef_i.p1, 2 * c_q.mxy, 20)
       + pldm_pkg::smul(coef_i.p2, c_q.rho2 + 2 * c_q.mx2, 20);
    dy = pldm_pkg::smul(c_q.ey, c_q.rad, 20)
       + pldm_pkg::smul(coef_i.p2, 2 * c_q.mxy, 20)
       + pldm_pkg::smul(coef_i.p1, c_q.rho2 + 2 * c_q.my2, 20);
    d_d = c_q;
    if (c_q.act && coef_i.dist_on) begin
      d_d.ex = c_q.ux - dx;
      d_d.ey = c_q.uy - dy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
    end
  end

  assign valid_o = vld_q[3];
  assign pt_o    = d_q;

endmodule

// ----- hw/rtl/pldm_proj.sv -----
// projection in six stages: distortion, focal scaling and principal point
module pldm_proj (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pldm_pkg::it_t   pt_i,
  input  pldm_pkg::coef_t coef_i,
  output logic            valid_o,
  output pldm_pkg::val_t  rx_o,
  output pldm_pkg::val_t  ry_o
);

  typedef struct packed {
    logic           act;
    pldm_pkg::val_t x;
    pldm_pkg::val_t y;
    pldm_pkg::val_t xx;
    pldm_pkg::val_t yy;
    pldm_pkg::val_t xy;
    pldm_pkg::val_t r2;
    pldm_pkg::val_t a1;
    pldm_pkg::val_t a2;
    pldm_pkg::val_t a3;
    pldm_pkg::val_t r4;
    pldm_pkg::val_t r6;
    pldm_pkg::val_t t1;
    pldm_pkg::val_t t2;
    pldm_pkg::val_t cd;
  } pj_t;

  pj_t        s1_q, s2_q, s3_q, s4_q, s1_d, s2_d, s3_d, s4_d;
  pldm_pkg::val_t xd_q, yd_q, xd_d, yd_d, rx_q, ry_q, rx_d, ry_d;
  logic       act5_q;
  logic [5:0] vld_q;

  // squares and cross product
  always_comb begin
    s1_d    = '0;
    s1_d.act = pt_i.act;
    s1_d.x  = pt_i.ex;
    s1_d.y  = pt_i.ey;
    s1_d.xx = pldm_pkg::smul(pt_i.ex, pt_i.ex, 16);
    s1_d.yy = pldm_pkg::smul(pt_i.ey, pt_i.ey, 16);
    s1_d.xy = pldm_pkg::smul(pt_i.ex, pt_i.ey, 16);
  end

  // radius terms and tangential arguments
  always_comb begin
    s2_d    = s1_q;
    s2_d.r2 = s1_q.xx + s1_q.yy;
    s2_d.a1 = 2 * s1_q.xy;
    s2_d.a2 = s2_d.r2 + 2 * s1_q.xx;
    s2_d.a3 = s2_d.r2 + 2 * s1_q.yy;
    s2_d.r4 = pldm_pkg::smul(s2_d.r2, s2_d.r2, 16);
  end

  // higher powers and radial products
  always_comb begin
    s3_d    = s2_q;
    s3_d.r6 = pldm_pkg::smul(s2_q.r4, s2_q.r2, 16);
    s3_d.t1 = pldm_pkg::smul(coef_i.k1, s2_q.r2, 16);
    s3_d.t2 = pldm_pkg::smul(coef_i.k2, s2_q.r4, 16);
  end

  // radial factor
  always_comb begin
    s4_d    = s3_q;
    s4_d.cd = pldm_pkg::ONE_Q20 + s3_q.t1 + s3_q.t2
            + pldm_pkg::smul(pldm_pkg::RADIAL_K3, s3_q.r6, 16);
  end

  // distorted point
  always_comb begin
    if (coef_i.dist_on) begin
      xd_d = pldm_pkg::smul(s4_q.x, s4_q.cd, 20) + pldm_pkg::smul(coef_i.p1, s4_q.a1, 20)
           + pldm_pkg::smul(coef_i.p2, s4_q.a2, 20);
      yd_d = pldm_pkg::smul(s4_q.y, s4_q.cd, 20) + pldm_pkg::smul(coef_i.p1, s4_q.a3, 20)
           + pldm_pkg::smul(coef_i.p2, s4_q.a1, 20);
    end else begin
      xd_d = s4_q.x;
      yd_d = s4_q.y;
    end
    if (s4_q.act) begin
      xd_d = s4_q.x;
      yd_d = s4_q.y;
    end
  end

  // pixel scaling, unprojected words pass
  always_comb begin
    if (act5_q) begin
      rx_d = xd_q;
      ry_d = yd_q;
    end else begin
      rx_d = pldm_pkg::smul(xd_q, 64'(coef_i.fx), 16) + 64'(coef_i.cx);
      ry_d = pldm_pkg::smul(yd_q, 64'(coef_i.fy), 16) + 64'(coef_i.cy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      s4_q   <= s4_d;
      xd_q   <= xd_d;
      yd_q   <= yd_d;
      act5_q <= s4_q.act;
      rx_q   <= rx_d;
      ry_q   <= ry_d;
    end
  end

  assign valid_o = vld_q[5];
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;

endmodule

// ----- hw/rtl/pinhole_lens_distortion_map.sv -----
// top level: registers, divider, undistortion iterations, projection and output clip
// pipeline: divider, eight undistortion iterations, projection and output register,
//   in that order from an accepted word to its result
// throughput: one word per cycle; the whole pipeline advances together and halts
//   while the output register holds a word that is not taken
// reset: asynchronous active low, clears all valid bits and restores the register values
module pinhole_lens_distortion_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // in_x[19:0], in_y[39:20]
  input  logic [0:0]  s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_x[19:0], out_y[39:20]
  output logic [0:0]  m_axis_tuser,   // saturated[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic signed [23:0] k1_q, k2_q, p1_q, p2_q;
  pldm_pkg::coef_t coef;
  logic en;

  logic          div_vld;
  pldm_pkg::it_t div_pt;
  logic          it_vld [pldm_pkg::ITERS+1];
  pldm_pkg::it_t it_pt  [pldm_pkg::ITERS+1];
  logic          pj_vld;
  pldm_pkg::val_t pj_rx, pj_ry;

  logic               out_vld_q;
  logic signed [19:0] out_x_q, out_y_q, out_x_d, out_y_d;
  logic               sat_q, sat_d;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= pldm_pkg::FOCAL_RST;
      focal_y_q  <= pldm_pkg::FOCAL_RST;
      center_x_q <= pldm_pkg::CENTER_X_RST;
      center_y_q <= pldm_pkg::CENTER_Y_RST;
      k1_q       <= '0;
      k2_q       <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (pldm_pkg::cfg_idx_e'(cfg_index_i))
        pldm_pkg::CFG_FOCAL_X:  focal_x_q  <= cfg_data_i[15:0];
        pldm_pkg::CFG_FOCAL_Y:  focal_y_q  <= cfg_data_i[15:0];
        pldm_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i[15:0];
        pldm_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i[15:0];
        pldm_pkg::CFG_K1:       k1_q       <= cfg_data_i;
        pldm_pkg::CFG_K2:       k2_q       <= cfg_data_i;
        pldm_pkg::CFG_P1:       p1_q       <= cfg_data_i;
        pldm_pkg::CFG_P2:       p2_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coefficient bundle, zero focal length read as one
  always_comb begin
    coef.dist_on = (k1_q >= pldm_pkg::K1_MIN);
    coef.k1   = 64'(k1_q);
    coef.k2   = 64'(k2_q);
    coef.p1   = 64'(p1_q);
    coef.p2   = 64'(p2_q);
    coef.fx   = (focal_x_q == '0) ? 16'd1 : focal_x_q;
    coef.fy   = (focal_y_q == '0) ? 16'd1 : focal_y_q;
    coef.cx   = center_x_q;
    coef.cy   = center_y_q;
  end

  // global advance
  assign en            = m_axis_tready | ~out_vld_q;
  assign s_axis_tready = en;

  pldm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .act_i   (s_axis_tuser[0]),
    .x_i     (s_axis_tdata[19:0]),
    .y_i     (s_axis_tdata[39:20]),
    .coef_i  (coef),
    .valid_o (div_vld),
    .pt_o    (div_pt)
  );

  assign it_vld[0] = div_vld;
  assign it_pt[0]  = div_pt;

  for (genvar g = 0; g < pldm_pkg::ITERS; g++) begin : g_iter
    pldm_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (it_vld[g]),
      .pt_i    (it_pt[g]),
      .coef_i  (coef),
      .valid_o (it_vld[g+1]),
      .pt_o    (it_pt[g+1])
    );
  end

  pldm_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (it_vld[pldm_pkg::ITERS]),
    .pt_i    (it_pt[pldm_pkg::ITERS]),
    .coef_i  (coef),
    .valid_o (pj_vld),
    .rx_o    (pj_rx),
    .ry_o    (pj_ry)
  );

  // clip to the field range
  always_comb begin
    sat_d = 1'b0;
    if (pj_rx > pldm_pkg::OUT_MAX) begin
      out_x_d = 20'sd524287;
      sat_d   = 1'b1;
    end else if (pj_rx < pldm_pkg::OUT_MIN) begin
      out_x_d = -20'sd524288;
      sat_d   = 1'b1;
    end else begin
      out_x_d = pj_rx[19:0];
    end
    if (pj_ry > pldm_pkg::OUT_MAX) begin
      out_y_d = 20'sd524287;
      sat_d   = 1'b1;
    end else if (pj_ry < pldm_pkg::OUT_MIN) begin
      out_y_d = -20'sd524288;
      sat_d   = 1'b1;
    end else begin
      out_y_d = pj_ry[19:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= pj_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      sat_q   <= sat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = sat_q;

endmodule

// ----- hw/rtl/pldm_checker.sv -----
// port level checks for the lens distortion mapper, bound to the top level
module pldm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed under stall");

  // input side only stalls while a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (m_axis_tready || !m_axis_tvalid))
    else $error("input ready does not follow output side");

  // clip flag only with a coordinate at a range limit
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[19:0] == 20'h7ffff) || (m_axis_tdata[19:0] == 20'h80000) ||
      (m_axis_tdata[39:20] == 20'h7ffff) || (m_axis_tdata[39:20] == 20'h80000))
    else $error("clip flag without clipped coordinate");

  // nothing offered just after reset is sampled active
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

endmodule

bind pinhole_lens_distortion_map pldm_checker u_pldm_checker (.*);
